@@ rtl/shs_pkg.sv @@
// Shared widths, round constants, initial hash and sigma functions for the SHA-256 hasher.
`default_nettype none

package shs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned DWORD_W = 64;
    localparam int unsigned IDX_W   = 2;

    // Block geometry: 64 bytes, length field starts at byte 56
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] RND_LAST  = 6'd63;
    localparam logic [IDX_W-1:0] WORD_IDX_LAST = 2'd3;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    localparam logic [WORD_W-1:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [WORD_W-1:0] f_bsig0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] f_bsig1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] f_ssig0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] f_ssig1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/shs_stream_if.sv @@
// Valid/ready channel interfaces for message bytes in and digest words out.
`default_nettype none

interface shs_in_if import shs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              no_byte;
    logic              finish;

    modport source (output valid, data_byte, no_byte, finish, input ready);
    modport sink   (input valid, data_byte, no_byte, finish, output ready);
endinterface

interface shs_out_if import shs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DWORD_W-1:0] digest_word;
    logic [IDX_W-1:0]   word_index;
    logic               last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

@@ rtl/sha256_stream_hasher_top.sv @@
// Streaming SHA-256 hasher: byte intake, padding sequencer, one-round-per-cycle compression.
//
//  channel  | dir | payload                              | beat
//  ---------+-----+--------------------------------------+------------------------------
//  i_in     | in  | data_byte[7:0], no_byte, finish      | one message byte or a close
//  o_out    | out | digest_word[63:0], word_index, last  | 4 beats per digest, big-endian
//
// A plain byte is taken while the hasher is idle; every 64th byte adds 64 rounds through
// the single round unit and a fold into the chaining state. A finish item adds padding at one
// byte per cycle up to the block end, one or two compressions, and a latch of the digest.
// The digest sits in its own register, so bytes of the next message are taken while it
// drains; a second digest waits until the first has gone.
// Reset (synchronous, active low) loads the initial hash and clears counts and handshakes.
`default_nettype none

module sha256_stream_hasher_top import shs_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    shs_in_if.sink    i_in,
    shs_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_chain [8];
    logic [WORD_W-1:0]   r_v [8];
    logic [511:0]        r_w;        // block bytes, later the 16-word schedule window
    logic [5:0]          r_fill;
    logic [5:0]          r_rnd;
    logic [DWORD_W-1:0]  r_total;
    logic [DWORD_W-1:0]  r_len;
    logic                r_fin;
    logic                r_mark;     // 0x80 still to be appended
    logic                r_lenblk;   // current block carries the length field
    logic [255:0]        r_dig;
    logic                r_obusy;
    logic [IDX_W-1:0]    r_oidx;

    logic [WORD_W-1:0]   w_t1;
    logic [WORD_W-1:0]   w_t2;
    logic [WORD_W-1:0]   w_sched;
    logic [BYTE_W-1:0]   w_pad_byte;
    logic [DWORD_W-1:0]  w_total_inc;
    logic                w_in_beat;
    logic                w_out_beat;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_out_beat = r_obusy && o_out.ready;

    assign o_out.valid       = r_obusy;
    assign o_out.digest_word = r_dig[255:192];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == WORD_IDX_LAST);

    assign w_total_inc = r_total + 64'd1;

    // Round unit: t1/t2 from working variables, window word 0 is w[t]
    assign w_t1 = r_v[7] + f_bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + K_TAB[r_rnd] + r_w[511:480];
    assign w_t2 = f_bsig0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    // w[t+16] = w[t] + s0(w[t+1]) + w[t+9] + s1(w[t+14])
    assign w_sched = r_w[511:480] + f_ssig0(r_w[479:448]) + r_w[223:192]
                   + f_ssig1(r_w[63:32]);

    always_comb begin
        if (r_mark) begin
            w_pad_byte = PAD_MARK;
        end else if (r_lenblk && (r_fill >= LEN_POS)) begin
            w_pad_byte = r_len[63:56];
        end else begin
            w_pad_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_chain  <= H_INIT;
            r_fill   <= '0;
            r_rnd    <= '0;
            r_total  <= '0;
            r_fin    <= 1'b0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_obusy  <= 1'b0;
            r_oidx   <= '0;
        end else begin
            if (w_out_beat) begin
                r_dig <= {r_dig[191:0], 64'd0};
                if (r_oidx == WORD_IDX_LAST) begin
                    r_obusy <= 1'b0;
                end else begin
                    r_oidx <= r_oidx + 2'd1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_fin    <= i_in.finish;
                        r_mark   <= i_in.finish;
                        r_lenblk <= 1'b0;
                        if (i_in.no_byte) begin
                            r_len <= {r_total[60:0], 3'b000};
                            if (i_in.finish) begin
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_len   <= {w_total_inc[60:0], 3'b000};
                            r_w     <= {r_w[503:0], i_in.data_byte};
                            r_total <= w_total_inc;
                            r_fill  <= r_fill + 6'd1;
                            if (r_fill == FILL_LAST) begin
                                r_state <= S_ROUND;
                                r_v     <= r_chain;
                                r_rnd   <= '0;
                            end else if (i_in.finish) begin
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_w    <= {r_w[503:0], w_pad_byte};
                    r_fill <= r_fill + 6'd1;
                    if (r_mark) begin
                        r_mark   <= 1'b0;
                        r_lenblk <= (r_fill < LEN_POS);
                    end else if (r_lenblk && (r_fill >= LEN_POS)) begin
                        r_len <= {r_len[55:0], 8'd0};
                    end
                    if (r_fill == FILL_LAST) begin
                        r_state <= S_ROUND;
                        r_v     <= r_chain;
                        r_rnd   <= '0;
                    end
                end
                S_ROUND: begin
                    r_v[0] <= w_t1 + w_t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    r_w    <= {r_w[479:0], w_sched};
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == RND_LAST) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_mark || !r_lenblk) begin
                        // padding not yet done: mark pending, or length needs its own block
                        r_state <= S_PAD;
                        if (!r_mark) begin
                            r_lenblk <= 1'b1;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the previous digest has drained
                    if (!r_obusy) begin
                        r_dig   <= {r_chain[0], r_chain[1], r_chain[2], r_chain[3],
                                    r_chain[4], r_chain[5], r_chain[6], r_chain[7]};
                        r_chain <= H_INIT;
                        r_total <= '0;
                        r_fin   <= 1'b0;
                        r_obusy <= 1'b1;
                        r_oidx  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_round_empty_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_fill == 6'd0))
        else $error("block fill count not cleared during compression");

    a_digest_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (o_out.word_index == 2'd0))
        else $error("digest does not start with word 0");

    a_last_word_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> !o_out.valid)
        else $error("output still valid after final digest word");

    a_finish_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.finish) |=> !i_in.ready)
        else $error("intake open right after a finish beat");

endmodule

`default_nettype wire
